>>> rtl/splms_pkg.sv
// ----------------------------------------------------------------------------
// splms_pkg
// shared types and constants for the sorted pool list with mark and sweep
// ----------------------------------------------------------------------------
package splms_pkg;

	localparam int POOL_ENTRIES_DEF = 32;
	localparam int CMDQ_DEPTH       = 2;

	typedef enum logic [2:0] {
		FUNC_INSERT   = 3'd0,
		FUNC_OR_FLAGS = 3'd1,
		FUNC_FIND     = 3'd2,
		FUNC_SWEEP    = 3'd3,
		FUNC_CLEAR    = 3'd4,
		FUNC_RSV5     = 3'd5,
		FUNC_RSV6     = 3'd6,
		FUNC_RSV7     = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RSV       = 2'd3
	} status_t;

	// class of work decided by the front end
	typedef enum logic [2:0] {
		OP_INSERT_HEAD,
		OP_INSERT_ORD,
		OP_OR_FLAGS,
		OP_FIND,
		OP_SWEEP,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_WALK,
		BK_LINK,
		BK_LINK2,
		BK_UNLINK,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] handle;
		logic signed [15:0] sort_key;
		logic        ordered;
		logic        make_current;
		logic        set_mark_two;
		logic [7:0]  flag_bits;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] entry_index;
		logic [7:0] entry_flag_value;
		logic [5:0] live_count;
		logic [5:0] freed_count;
	} out_word_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] handle;
		logic signed [15:0] sort_key;
		logic        make_current;
		logic        set_mark_two;
		logic [7:0]  flag_bits;
	} cmd_t;

endpackage

>>> rtl/splms_front.sv
// ----------------------------------------------------------------------------
// splms_front
// accepts input words, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module splms_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  splms_pkg::in_word_t in_word,
	output logic                cmd_valid,
	input  logic                cmd_take,
	output splms_pkg::cmd_t     cmd
);

	localparam int D = splms_pkg::CMDQ_DEPTH;
	localparam int AW = (D > 1) ? $clog2(D) : 1;

	splms_pkg::cmd_t  mem_q [D];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	splms_pkg::cmd_t  cls;
	logic             do_push, do_pop;

	always_comb begin
		cls.handle       = in_word.handle;
		cls.sort_key     = in_word.sort_key;
		cls.make_current = in_word.make_current;
		cls.set_mark_two = in_word.set_mark_two;
		cls.flag_bits    = in_word.flag_bits;
		unique case (splms_pkg::func_t'(in_word.func))
			splms_pkg::FUNC_INSERT:
				cls.op = in_word.ordered ? splms_pkg::OP_INSERT_ORD : splms_pkg::OP_INSERT_HEAD;
			splms_pkg::FUNC_OR_FLAGS: cls.op = splms_pkg::OP_OR_FLAGS;
			splms_pkg::FUNC_FIND:     cls.op = splms_pkg::OP_FIND;
			splms_pkg::FUNC_SWEEP:    cls.op = splms_pkg::OP_SWEEP;
			splms_pkg::FUNC_CLEAR:    cls.op = splms_pkg::OP_CLEAR;
			default:                  cls.op = splms_pkg::OP_NOP;
		endcase
	end

	assign full      = (cnt_q == (AW+1)'(D));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(D-1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == AW'(D-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(D)) else $error("command queue overfilled");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !cmd_valid) else $error("valid without command");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !do_pop) |=> full) else $error("full dropped without pop");

endmodule

>>> rtl/splms_back.sv
// ----------------------------------------------------------------------------
// splms_back
// linked list engine: relinks entries and, apart from an unlink step per freed entry, walks them one per cycle
// ----------------------------------------------------------------------------
module splms_back #(
	parameter int POOL_ENTRIES = splms_pkg::POOL_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_take,
	input  splms_pkg::cmd_t      cmd,
	output logic                 res_valid,
	input  logic                 res_take,
	output splms_pkg::out_word_t res
);

	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam int IW = $clog2(POOL_ENTRIES);
	localparam int CW = $clog2(POOL_ENTRIES + 1);
	localparam logic [LW-1:0] SENT = LW'(POOL_ENTRIES);

	// link state: valid bits restore the reset chain without a clearing pass;
	// the sentinel's two links are plain registers
	logic [LW-1:0] nxt_q [POOL_ENTRIES];
	logic [LW-1:0] prv_q [POOL_ENTRIES];
	logic [POOL_ENTRIES-1:0] lv_q;
	logic [LW-1:0] head_q, tail_q;
	logic [15:0]   key_mem [POOL_ENTRIES];
	logic [15:0]   hdl_mem [POOL_ENTRIES];
	logic [7:0]    flg_q   [POOL_ENTRIES];

	logic [LW-1:0] free_q, cur_q;
	logic [CW-1:0] live_q, freed_q;

	splms_pkg::bk_state_t st_q, st_d;
	splms_pkg::cmd_t      c_q;
	logic [LW-1:0]        p_q, s_q, nx_q;
	logic [15:0]          rkey_q, rhdl_q;
	splms_pkg::out_word_t res_q;
	logic                 rv_q;

	function automatic logic [LW-1:0] rdn(input logic [LW-1:0] a,
	                                     input logic [LW-1:0] n [POOL_ENTRIES],
	                                     input logic [POOL_ENTRIES-1:0] v,
	                                     input logic [LW-1:0] hd);
		logic [LW-1:0] r;
		if (a == SENT) r = hd;
		else if (v[a[IW-1:0]]) r = n[a[IW-1:0]];
		else r = a + 1'b1;
		return r;
	endfunction

	function automatic logic [LW-1:0] rdp(input logic [LW-1:0] a,
	                                     input logic [LW-1:0] p [POOL_ENTRIES],
	                                     input logic [POOL_ENTRIES-1:0] v,
	                                     input logic [LW-1:0] tl);
		logic [LW-1:0] r;
		if (a == SENT) r = tl;
		else if (v[a[IW-1:0]]) r = p[a[IW-1:0]];
		else r = '0;
		return r;
	endfunction

	// valid bit of a slot, nothing for the sentinel
	function automatic logic [POOL_ENTRIES-1:0] slot_bit(input logic [LW-1:0] a);
		logic [POOL_ENTRIES-1:0] r;
		r = '0;
		if (a != SENT) r[a[IW-1:0]] = 1'b1;
		return r;
	endfunction

	logic [LW-1:0] n_of_p, p_of_p;
	logic [7:0]    f_p;
	assign n_of_p = rdn(p_q, nxt_q, lv_q, head_q);
	assign p_of_p = rdp(p_q, prv_q, lv_q, tail_q);
	assign f_p    = flg_q[p_q[IW-1:0]];

	assign cmd_take  = (st_q == splms_pkg::BK_IDLE) && cmd_valid;
	assign res_valid = rv_q;
	assign res       = res_q;

	logic walk_end;
	always_comb begin
		walk_end = 1'b0;
		st_d = st_q;
		unique case (st_q)
			splms_pkg::BK_IDLE: if (cmd_valid) st_d = splms_pkg::BK_READ;
			splms_pkg::BK_READ: begin
				priority case (c_q.op)
					splms_pkg::OP_INSERT_HEAD:
						st_d = (free_q == SENT) ? splms_pkg::BK_DONE : splms_pkg::BK_LINK;
					splms_pkg::OP_NOP: st_d = splms_pkg::BK_DONE;
					default:
						st_d = (c_q.op == splms_pkg::OP_INSERT_ORD && free_q == SENT)
							? splms_pkg::BK_DONE : splms_pkg::BK_WALK;
				endcase
			end
			splms_pkg::BK_WALK: begin
				priority case (c_q.op)
					splms_pkg::OP_INSERT_ORD:
						walk_end = (p_q == SENT) ||
							($signed(c_q.sort_key) < $signed(rkey_q));
					splms_pkg::OP_OR_FLAGS, splms_pkg::OP_FIND:
						walk_end = (p_q == SENT) || (rhdl_q == c_q.handle);
					default: walk_end = (p_q == SENT);
				endcase
				if (walk_end)
					st_d = (c_q.op == splms_pkg::OP_INSERT_ORD) ? splms_pkg::BK_LINK
					                                            : splms_pkg::BK_DONE;
				else if ((c_q.op == splms_pkg::OP_CLEAR) ||
				         (c_q.op == splms_pkg::OP_SWEEP && !f_p[0]))
					st_d = splms_pkg::BK_UNLINK;
			end
			splms_pkg::BK_UNLINK: st_d = splms_pkg::BK_WALK;
			splms_pkg::BK_LINK:   st_d = splms_pkg::BK_LINK2;
			splms_pkg::BK_LINK2:  st_d = splms_pkg::BK_DONE;
			splms_pkg::BK_DONE:   if (!rv_q || res_take) st_d = splms_pkg::BK_IDLE;
			default:              st_d = splms_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= splms_pkg::BK_IDLE;
		else         st_q <= st_d;
	end

	// key and handle reads are registered and follow the walk pointer
	logic [LW-1:0] rd_addr;
	always_comb begin
		rd_addr = p_q;
		if (st_q == splms_pkg::BK_READ) rd_addr = head_q;
		else if (st_q == splms_pkg::BK_WALK) rd_addr = n_of_p;
		else if (st_q == splms_pkg::BK_UNLINK) rd_addr = nx_q;
	end

	always_ff @(posedge clk) begin
		if (rd_addr != SENT) begin
			rkey_q <= key_mem[rd_addr[IW-1:0]];
			rhdl_q <= hdl_mem[rd_addr[IW-1:0]];
		end
		if (st_q == splms_pkg::BK_IDLE && cmd_valid) c_q <= cmd;
		if (st_q == splms_pkg::BK_LINK && c_q.op == splms_pkg::OP_INSERT_HEAD) begin
			key_mem[s_q[IW-1:0]] <= c_q.sort_key;
			hdl_mem[s_q[IW-1:0]] <= c_q.handle;
		end
		if (st_q == splms_pkg::BK_READ && c_q.op == splms_pkg::OP_INSERT_ORD &&
		    free_q != SENT) begin
			key_mem[free_q[IW-1:0]] <= c_q.sort_key;
			hdl_mem[free_q[IW-1:0]] <= c_q.handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q    <= '0;
			head_q  <= SENT;
			tail_q  <= SENT;
			free_q  <= '0;
			cur_q   <= SENT;
			live_q  <= '0;
			freed_q <= '0;
			rv_q    <= 1'b0;
			p_q     <= SENT;
			s_q     <= SENT;
			nx_q    <= SENT;
		end else begin
			rv_q <= (rv_q && !res_take) ||
			        (st_q == splms_pkg::BK_DONE && (!rv_q || res_take));
			unique case (st_q)
				splms_pkg::BK_READ: begin
					// a full pool leaves s_q at the sentinel
					freed_q <= '0;
					s_q     <= free_q;
					p_q     <= (c_q.op == splms_pkg::OP_INSERT_HEAD) ? SENT : head_q;
				end
				splms_pkg::BK_WALK: begin
					if (!walk_end) begin
						nx_q <= n_of_p;
						if (c_q.op == splms_pkg::OP_SWEEP && f_p[0])
							flg_q[p_q[IW-1:0]] <= f_p & 8'hFE;
						if (!((c_q.op == splms_pkg::OP_CLEAR) ||
						      (c_q.op == splms_pkg::OP_SWEEP && !f_p[0])))
							p_q <= n_of_p;
					end else if (c_q.op == splms_pkg::OP_INSERT_ORD) begin
						p_q <= p_of_p;
					end
				end
				splms_pkg::BK_UNLINK: begin
					if (p_of_p == SENT) head_q <= nx_q;
					else nxt_q[p_of_p[IW-1:0]] <= nx_q;
					if (nx_q == SENT) tail_q <= p_of_p;
					else begin
						prv_q[nx_q[IW-1:0]] <= p_of_p;
						if (!lv_q[nx_q[IW-1:0]])
							nxt_q[nx_q[IW-1:0]] <= rdn(nx_q, nxt_q, lv_q, head_q);
					end
					nxt_q[p_q[IW-1:0]] <= free_q;
					if (!lv_q[p_q[IW-1:0]]) prv_q[p_q[IW-1:0]] <= '0;
					lv_q          <= lv_q | slot_bit(p_of_p) | slot_bit(nx_q) |
					                 slot_bit(p_q);
					free_q        <= p_q;
					if (live_q != '0) live_q <= live_q - 1'b1;
					freed_q       <= freed_q + 1'b1;
					p_q           <= nx_q;
				end
				splms_pkg::BK_LINK: begin
					// p_q is the entry after which the new one goes
					free_q          <= rdn(s_q, nxt_q, lv_q, head_q);
					nx_q            <= rdn(p_q, nxt_q, lv_q, head_q);
					flg_q[s_q[IW-1:0]] <= c_q.set_mark_two ? 8'h02 : 8'h00;
				end
				splms_pkg::BK_LINK2: begin
					prv_q[s_q[IW-1:0]] <= p_q;
					nxt_q[s_q[IW-1:0]] <= nx_q;
					if (nx_q == SENT) tail_q <= s_q;
					else begin
						prv_q[nx_q[IW-1:0]] <= s_q;
						if (!lv_q[nx_q[IW-1:0]])
							nxt_q[nx_q[IW-1:0]] <= rdn(nx_q, nxt_q, lv_q, head_q);
					end
					if (p_q == SENT) head_q <= s_q;
					else begin
						nxt_q[p_q[IW-1:0]] <= s_q;
						if (!lv_q[p_q[IW-1:0]])
							prv_q[p_q[IW-1:0]] <= rdp(p_q, prv_q, lv_q, tail_q);
					end
					lv_q        <= lv_q | slot_bit(s_q) | slot_bit(nx_q) | slot_bit(p_q);
					live_q      <= live_q + 1'b1;
					if (c_q.make_current) cur_q <= s_q;
				end
				splms_pkg::BK_DONE: begin
					if (!rv_q || res_take) begin
						res_q.status           <= splms_pkg::ST_OK;
						res_q.entry_index      <= '0;
						res_q.entry_flag_value <= '0;
						res_q.live_count       <= 6'(live_q);
						res_q.freed_count      <= '0;
						priority case (c_q.op)
							splms_pkg::OP_INSERT_HEAD, splms_pkg::OP_INSERT_ORD: begin
								if (free_q == SENT && s_q == SENT) begin
									res_q.status <= splms_pkg::ST_POOL_FULL;
									if (c_q.make_current) cur_q <= SENT;
								end else begin
									res_q.entry_index      <= 5'(s_q);
									res_q.entry_flag_value <= flg_q[s_q[IW-1:0]];
								end
							end
							splms_pkg::OP_OR_FLAGS, splms_pkg::OP_FIND: begin
								if (p_q == SENT) res_q.status <= splms_pkg::ST_NOT_FOUND;
								else begin
									res_q.entry_index <= 5'(p_q);
									if (c_q.op == splms_pkg::OP_OR_FLAGS) begin
										flg_q[p_q[IW-1:0]] <= f_p | c_q.flag_bits;
										res_q.entry_flag_value <= f_p | c_q.flag_bits;
									end else begin
										cur_q <= p_q;
										res_q.entry_flag_value <= f_p;
									end
								end
							end
							splms_pkg::OP_SWEEP, splms_pkg::OP_CLEAR:
								res_q.freed_count <= 6'(freed_q);
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(POOL_ENTRIES)) else $error("live count beyond pool");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> (st_q == splms_pkg::BK_READ)) else $error("take not followed by read");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && !res_take) |=> (rv_q && $stable(res_q))) else $error("result lost");

endmodule

>>> rtl/sorted_pool_list_with_mark_sweep.sv
// ----------------------------------------------------------------------------
// sorted_pool_list_with_mark_sweep
// pool of entries in a doubly linked list with sorted insert by key, mark and sweep
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: drive in_word and push; a word is taken at a
//   clock edge with push high and full low
//   result side is a queue: while empty is low the oldest result word sits
//   on out_word; pop with empty low takes it
//   every input word yields exactly one result word, in order
// flow
//   a front stage classifies words into a two deep command queue; the back
//   engine walks the linked list one entry per cycle, plus an unlink step
//   for each entry that a sweep or clear frees, and takes the next command
//   only when it is back in its idle state
// reset
//   arst_n clears the list to empty with the free chain in slot order at
//   once, using per link valid bits; no clearing pass is needed
// stalls
//   a result word waits in the output register; the engine holds in its
//   done state until taken while the front keeps queueing commands
// ----------------------------------------------------------------------------
module sorted_pool_list_with_mark_sweep #(
	parameter int POOL_ENTRIES = splms_pkg::POOL_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  splms_pkg::in_word_t  in_word,
	output logic                 empty,
	input  logic                 pop,
	output splms_pkg::out_word_t out_word
);

	logic            cmd_valid, cmd_take, res_valid;
	splms_pkg::cmd_t cmd;

	// front end: accept and classify
	splms_front u_front (
		.clk, .arst_n, .push, .full, .in_word,
		.cmd_valid, .cmd_take, .cmd
	);

	// back end: list engine with output register
	splms_back #(.POOL_ENTRIES(POOL_ENTRIES)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.res_valid, .res_take(pop), .res(out_word)
	);

	assign empty = !res_valid;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted pool list: a table of directed words,
// then random insert / mark / find / sweep sequences checked against a
// behavioral model of the pool, with random gaps and a long pop hold-off
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NSLOT     = 32;
	localparam int SENT      = NSLOT;          // sentinel slot of the live list
	localparam int N_RANDOM  = 830;
	localparam int CYC_LIMIT = 1000000;
	localparam int DRAIN_CYC = 2 * NSLOT + 20;
	localparam int LONG_HOLD = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 pop = 1'b0;
	logic                 full;
	logic                 empty;
	splms_pkg::in_word_t  in_word = '0;
	splms_pkg::out_word_t out_word;

	always #1 clk = ~clk;

	sorted_pool_list_with_mark_sweep u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.in_word(in_word), .empty(empty), .pop(pop), .out_word(out_word)
	);

	// ---------------------------------------------------------------------
	// pool model: stores, links, free chain, selection, live count
	// ---------------------------------------------------------------------
	logic signed [15:0] m_key [NSLOT];
	logic [15:0] m_hdl [NSLOT];
	logic [7:0]  m_flg [NSLOT];
	int          m_nxt [NSLOT+1];
	int          m_prv [NSLOT+1];
	int          m_free;
	int          m_sel;
	int          m_live;

	splms_pkg::out_word_t pending_results[$];
	logic [15:0] live_handles[$];     // handles that may be in the list, for hits
	int          n_err = 0;
	int          n_checked = 0;
	int          n_full_seen = 0;
	int          n_miss_seen = 0;
	int          n_swept = 0;
	longint      cyc = 0;
	bit          stim_done = 0;
	bit          hold_pop = 0;

	task automatic pool_reset();
		for (int i = 0; i < NSLOT; i++) begin
			m_nxt[i] = i + 1;
			m_prv[i] = 0;
		end
		m_nxt[SENT] = SENT;
		m_prv[SENT] = SENT;
		m_free = 0;
		m_sel  = SENT;
		m_live = 0;
	endtask

	task automatic pool_free(input int s);
		m_nxt[m_prv[s]] = m_nxt[s];
		m_prv[m_nxt[s]] = m_prv[s];
		m_nxt[s] = m_free;
		m_free = s;
		if (m_live > 0) m_live--;
	endtask

	function automatic int pool_lookup(input logic [15:0] h);
		int i;
		i = m_nxt[SENT];
		while (i != SENT && m_hdl[i] != h) i = m_nxt[i];
		return i;
	endfunction

	// apply one word to the model and give the result it must produce
	task automatic pool_apply(input splms_pkg::in_word_t w,
	                          output splms_pkg::out_word_t r);
		int s, p, aft, nx, fr;
		r = '0;
		fr = 0;
		case (splms_pkg::func_t'(w.func))
			splms_pkg::FUNC_INSERT: begin
				s = m_free;
				if (s == SENT) begin
					r.status = splms_pkg::ST_POOL_FULL;
					if (w.make_current) m_sel = SENT;
				end else begin
					m_free = m_nxt[s];
					m_hdl[s] = w.handle;
					m_key[s] = w.sort_key;
					m_flg[s] = w.set_mark_two ? 8'h02 : 8'h00;
					aft = SENT;
					if (w.ordered) begin
						p = m_nxt[SENT];
						// equal keys go behind existing ones
						while (p != SENT && !(w.sort_key < m_key[p])) p = m_nxt[p];
						aft = m_prv[p];
					end
					nx = m_nxt[aft];
					m_prv[s] = aft;
					m_nxt[s] = nx;
					m_prv[nx] = s;
					m_nxt[aft] = s;
					m_live++;
					if (w.make_current) m_sel = s;
					r.entry_index = s[4:0];
					r.entry_flag_value = m_flg[s];
				end
			end
			splms_pkg::FUNC_OR_FLAGS, splms_pkg::FUNC_FIND: begin
				s = pool_lookup(w.handle);
				if (s == SENT) r.status = splms_pkg::ST_NOT_FOUND;
				else begin
					if (splms_pkg::func_t'(w.func) == splms_pkg::FUNC_OR_FLAGS)
						m_flg[s] |= w.flag_bits;
					else m_sel = s;
					r.entry_index = s[4:0];
					r.entry_flag_value = m_flg[s];
				end
			end
			splms_pkg::FUNC_SWEEP: begin
				s = m_nxt[SENT];
				while (s != SENT) begin
					nx = m_nxt[s];
					if (m_flg[s][0]) m_flg[s][0] = 1'b0;
					else begin
						pool_free(s);
						fr++;
					end
					s = nx;
				end
			end
			splms_pkg::FUNC_CLEAR: begin
				s = m_nxt[SENT];
				while (s != SENT) begin
					nx = m_nxt[s];
					pool_free(s);
					fr++;
					s = nx;
				end
			end
			default: ;
		endcase
		r.live_count  = m_live[5:0];
		r.freed_count = fr[5:0];
	endtask

	// ---------------------------------------------------------------------
	// sender: one word per handshake, random gaps; push stays high between
	// back to back words and drops only for a gap
	// ---------------------------------------------------------------------
	task automatic send_word(input splms_pkg::in_word_t w);
		splms_pkg::out_word_t r;
		pool_apply(w, r);
		if (r.status == splms_pkg::ST_POOL_FULL) n_full_seen++;
		if (r.status == splms_pkg::ST_NOT_FOUND) n_miss_seen++;
		if (splms_pkg::func_t'(w.func) == splms_pkg::FUNC_INSERT)
			live_handles.push_back(w.handle);
		if (splms_pkg::func_t'(w.func) == splms_pkg::FUNC_CLEAR) live_handles.delete();
		pending_results.push_back(r);
		in_word <= w;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_gap();
		int g;
		g = ($urandom_range(0, 9) < 6) ? 0 :
		    ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic splms_pkg::in_word_t mk(input splms_pkg::func_t f,
	                                input logic [15:0] h,
	                                input logic [15:0] k, input logic o,
	                                input logic mc, input logic m2,
	                                input logic [7:0] fb);
		splms_pkg::in_word_t w;
		w.func = f; w.handle = h; w.sort_key = k; w.ordered = o;
		w.make_current = mc; w.set_mark_two = m2; w.flag_bits = fb;
		return w;
	endfunction

	// random word weighted toward inserts, with handles often reused so
	// that or-flags and find mostly hit
	function automatic splms_pkg::in_word_t rand_word(input int bias_insert);
		splms_pkg::in_word_t w;
		int r;
		w = '0;
		w.handle       = 16'($urandom());
		w.sort_key     = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
		                 16'($signed($urandom_range(0, 15)) - 8);
		w.ordered      = $urandom_range(0, 3) != 0;
		w.make_current = 1'($urandom());
		w.set_mark_two = 1'($urandom());
		w.flag_bits    = 8'($urandom());
		r = $urandom_range(0, 99);
		if (r < bias_insert) w.func = splms_pkg::FUNC_INSERT;
		else if (r < bias_insert + 25) w.func = splms_pkg::FUNC_OR_FLAGS;
		else if (r < bias_insert + 45) w.func = splms_pkg::FUNC_FIND;
		else if (r < 96) w.func = splms_pkg::FUNC_SWEEP;
		else if (r < 98) w.func = splms_pkg::FUNC_CLEAR;
		else w.func = 3'($urandom_range(5, 7));
		if (w.func != splms_pkg::FUNC_INSERT && live_handles.size() > 0 &&
		    $urandom_range(0, 9) < 8)
			w.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
		if (w.func == splms_pkg::FUNC_OR_FLAGS && $urandom_range(0, 1)) w.flag_bits[0] = 1'b1;
		return w;
	endfunction

	// directed table: expected word typed in where it is obvious, else model
	typedef struct {
		splms_pkg::in_word_t  w;
		bit                   fixed;
		splms_pkg::out_word_t r;
	} dir_row_t;

	dir_row_t dir_tab[$];

	task automatic add_row(input splms_pkg::in_word_t w, input bit fx,
	                       input logic [1:0] st,
	                       input logic [4:0] ix, input logic [7:0] fl,
	                       input logic [5:0] lv, input logic [5:0] fr);
		dir_row_t d;
		d.w = w; d.fixed = fx;
		d.r.status = st; d.r.entry_index = ix; d.r.entry_flag_value = fl;
		d.r.live_count = lv; d.r.freed_count = fr;
		dir_tab.push_back(d);
	endtask

	initial begin
		splms_pkg::out_word_t chk;
		pool_reset();
		// empty list: misses, empty sweep and clear, an unknown func
		add_row(mk(splms_pkg::FUNC_FIND, 16'h0000, 0, 0, 0, 0, 0), 1,
		        splms_pkg::ST_NOT_FOUND, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_OR_FLAGS, 16'hFFFF, 0, 0, 0, 0, 8'hFF), 1,
		        splms_pkg::ST_NOT_FOUND, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_SWEEP, 0, 0, 0, 0, 0, 0), 1, splms_pkg::ST_OK, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0), 1, splms_pkg::ST_OK, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_RSV7, 16'hFFFF, 16'hFFFF, 1, 1, 1, 8'hFF), 1,
		        splms_pkg::ST_OK, 0, 0, 0, 0);
		// head and ordered inserts, key extremes, equal keys, marks, finds, unknown funcs, sweeps, a clear
		add_row(mk(splms_pkg::FUNC_INSERT, 16'hFFFF, 16'h7FFF, 1, 1, 1, 0), 1,
		        splms_pkg::ST_OK, 0, 8'h02, 1, 0);
		add_row(mk(splms_pkg::FUNC_INSERT, 16'h0000, 16'h8000, 1, 0, 0, 0), 1,
		        splms_pkg::ST_OK, 1, 8'h00, 2, 0);
		add_row(mk(splms_pkg::FUNC_INSERT, 16'h1234, 16'h0000, 1, 0, 1, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_INSERT, 16'h1235, 16'h0000, 1, 1, 0, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_INSERT, 16'h5555, 16'h7FFF, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_OR_FLAGS, 16'h1234, 0, 0, 0, 0, 8'hFF), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_OR_FLAGS, 16'hFFFF, 0, 0, 0, 0, 8'h01), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_FIND, 16'h0000, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_FIND, 16'hAAAA, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_RSV5, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_SWEEP, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_SWEEP, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_RSV6, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);
		add_row(mk(splms_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_word(dir_tab[i].w);
			if (dir_tab[i].fixed) begin
				chk = pending_results[$];
				if (chk != dir_tab[i].r) begin
					$error("directed row %0d: result word exp %h got %h",
					       i, dir_tab[i].r, chk);
					n_err++;
				end
			end
			send_gap();
		end

		// fill the pool to overflow while the receiver holds off
		hold_pop = 1;
		for (int i = 0; i < NSLOT + 3; i++)
			send_word(mk(splms_pkg::FUNC_INSERT, 16'($urandom()), 16'($urandom()),
			             1'($urandom()), i == NSLOT + 1, 1'($urandom()), 0));
		hold_pop = 0;

		// random part: phases lean toward filling or toward draining
		for (int i = 0; i < N_RANDOM; i++) begin
			send_word(rand_word(((i / 100) % 2) ? 30 : 55));
			if (i % 150 == 149) live_handles.delete();
			send_gap();
		end
		push <= 1'b0;
		stim_done = 1;
	end

	// ---------------------------------------------------------------------
	// receiver: random pop, one long hold-off counted here
	// ---------------------------------------------------------------------
	initial begin
		int stall;
		bit held;
		stall = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_pop && !held) begin
				held = 1;
				stall = LONG_HOLD;
				pop <= 1'b0;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else if ((cyc / 2000) % 3 == 0) begin
				pop <= 1'b1;          // stretch with no idling
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 9) < 3)
					stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
					                                     : $urandom_range(1, 3);
			end
		end
	end

	// compare each accepted result with the oldest expected one
	always @(posedge clk) begin
		splms_pkg::out_word_t exp_w;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: %h", out_word);
				n_err++;
			end else begin
				exp_w = pending_results.pop_front();
				n_checked++;
				if (exp_w.freed_count != 0) n_swept++;
				if (out_word.status !== exp_w.status) begin
					$error("status exp %0d got %0d", exp_w.status, out_word.status);
					n_err++;
				end
				if (out_word.entry_index !== exp_w.entry_index) begin
					$error("entry_index exp %0d got %0d", exp_w.entry_index,
					       out_word.entry_index);
					n_err++;
				end
				if (out_word.entry_flag_value !== exp_w.entry_flag_value) begin
					$error("entry_flag_value exp %h got %h", exp_w.entry_flag_value,
					       out_word.entry_flag_value);
					n_err++;
				end
				if (out_word.live_count !== exp_w.live_count) begin
					$error("live_count exp %0d got %0d", exp_w.live_count,
					       out_word.live_count);
					n_err++;
				end
				if (out_word.freed_count !== exp_w.freed_count) begin
					$error("freed_count exp %0d got %0d", exp_w.freed_count,
					       out_word.freed_count);
					n_err++;
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		@(posedge arst_n);
		while (!(stim_done && pending_results.size() == 0) && cyc < CYC_LIMIT)
			@(posedge clk);
		if (cyc < CYC_LIMIT) repeat (DRAIN_CYC) @(posedge clk);
		if (cyc >= CYC_LIMIT) begin
			$display("timeout with %0d words outstanding", pending_results.size());
			$display("RESULT: ERROR");
		end else begin
			$display("checked %0d result words: %0d pool-full, %0d misses, %0d frees",
			         n_checked, n_full_seen, n_miss_seen, n_swept);
			if (n_err == 0) $display("RESULT: OK");
			else $display("RESULT: ERROR");
		end
		$finish;
	end

	always @(posedge clk) cyc <= cyc + 1;

endmodule

>>> files.f
rtl/splms_pkg.sv
rtl/splms_front.sv
rtl/splms_back.sv
rtl/sorted_pool_list_with_mark_sweep.sv
tb/sv/tb_top.sv
